FILE: sv/e8cpu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8cpu_pkg
// Shared types and constants for the 8-bit CPU execute unit: operation
// codes, flag bit positions, the register file and the decoded controls.
// ----------------------------------------------------------------------------
package e8cpu_pkg;

    localparam int IN_W  = 16;
    localparam int OUT_W = 56;

    // flag_bits layout: N V B D I Z C at bits 6..0
    localparam int FL_C = 0;
    localparam int FL_Z = 1;
    localparam int FL_I = 2;
    localparam int FL_D = 3;
    localparam int FL_B = 4;
    localparam int FL_V = 5;
    localparam int FL_N = 6;

    localparam logic [7:0] SP_RESET = 8'hFF;

    // branch flag select, taken from opcode bits 7:6
    localparam logic [1:0] BSEL_N = 2'd0;
    localparam logic [1:0] BSEL_V = 2'd1;
    localparam logic [1:0] BSEL_C = 2'd2;
    localparam logic [1:0] BSEL_Z = 2'd3;

    typedef enum logic [5:0] {
        OP_BAD,
        OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR,
        OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A,
        OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M,
        OP_INC_M, OP_DEC_M,
        OP_BRANCH, OP_BIT,
        OP_CLC, OP_SEC, OP_CLD, OP_SED, OP_CLI, OP_SEI, OP_CLV,
        OP_CMP, OP_CPX, OP_CPY,
        OP_DEX, OP_DEY, OP_INX, OP_INY,
        OP_LDA, OP_LDX, OP_LDY, OP_NOP,
        OP_PHA, OP_PHP, OP_PLA, OP_PLP,
        OP_STA, OP_STX, OP_STY,
        OP_TAX, OP_TAY, OP_TSX, OP_TXA, OP_TXS, OP_TYA
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [1:0] bsel;
        logic       bsense;
    } t_ctl;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] sp;
        logic [6:0] flags;
    } t_regs;

    function automatic logic [7:0] pack_status(logic [6:0] f);
        return {f[FL_N], f[FL_V], 1'b1, f[FL_B:FL_C]};
    endfunction

endpackage

FILE: sv/eight_bit_cpu_execute_unit_core.sv
`timescale 1ns / 1ps
// Executes one 8-bit instruction per transfer at a sustained rate of one per
// cycle while the output is not stalled. A transfer is taken into the input
// register, decoded and executed against A, X, Y, SP and the flags, and lands
// in the result register. The register file is updated in the same cycle the
// item enters the result register, so the next item sees it at once. The
// input side stalls only while a result is held unread and the input
// register is already full.
// ----------------------------------------------------------------------------
// eight_bit_cpu_execute_unit_core
// Top level: input register, decoder, execute logic, register file and
// result register on stream interfaces.
// ----------------------------------------------------------------------------
module eight_bit_cpu_execute_unit_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [7:0] req_type, [15:8] operand_byte
    input  logic [e8cpu_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] write_data, [8] write_enable, [9] branch_taken, [17:10] acc_out,
    // [25:18] x_out, [33:26] y_out, [41:34] stack_out, [49:42] status_out,
    // [50] bad_opcode, [55:51] zero
    output logic [e8cpu_pkg::OUT_W-1:0]  m_axis_tdata
);
    import e8cpu_pkg::*;

    logic              r_in_valid;
    logic [IN_W-1:0]   r_in_data;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;
    t_regs             r_regs;
    t_regs             n_regs;
    logic [OUT_W-1:0]  n_out_data;

    t_ctl              w_ctl;
    logic [7:0]        w_wdata;
    logic              w_wen;
    logic              w_branch;
    logic              w_bad;
    logic              w_move;

    assign w_move        = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_move;

    e8cpu_decode u_decode (
        .i_opcode (r_in_data[7:0]),
        .o_ctl    (w_ctl)
    );

    e8cpu_alu u_alu (
        .i_ctl     (w_ctl),
        .i_operand (r_in_data[15:8]),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_wdata   (w_wdata),
        .o_wen     (w_wen),
        .o_branch  (w_branch),
        .o_bad     (w_bad)
    );

    assign n_out_data = {5'b0, w_bad, pack_status(n_regs.flags), n_regs.sp, n_regs.y,
                         n_regs.x, n_regs.acc, w_branch, w_wen, w_wdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_regs.acc   <= 8'h00;
            r_regs.x     <= 8'h00;
            r_regs.y     <= 8'h00;
            r_regs.sp    <= SP_RESET;
            r_regs.flags <= 7'h00;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_move) begin
                r_out_valid <= 1'b1;
                r_regs      <= n_regs;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data <= s_axis_tdata;
        end
        if (w_move) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: sv/e8cpu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8cpu_decode
// Opcode decoder: maps an opcode byte to an operation and branch controls.
// ----------------------------------------------------------------------------
module e8cpu_decode (
    input  logic [7:0]        i_opcode,
    output e8cpu_pkg::t_ctl   o_ctl
);
    import e8cpu_pkg::*;

    t_op w_op;

    always_comb begin
        unique case (i_opcode)
            8'h69, 8'h65, 8'h75, 8'h6D, 8'h7D, 8'h79, 8'h61, 8'h71: w_op = OP_ADC;
            8'hE9, 8'hE5, 8'hF5, 8'hED, 8'hFD, 8'hF9, 8'hE1, 8'hF1: w_op = OP_SBC;
            8'h29, 8'h25, 8'h35, 8'h2D, 8'h3D, 8'h39, 8'h21, 8'h31: w_op = OP_AND;
            8'h09, 8'h05, 8'h15, 8'h0D, 8'h1D, 8'h19, 8'h01, 8'h11: w_op = OP_ORA;
            8'h49, 8'h45, 8'h55, 8'h4D, 8'h5D, 8'h59, 8'h41, 8'h51: w_op = OP_EOR;
            8'h0A: w_op = OP_ASL_A;
            8'h4A: w_op = OP_LSR_A;
            8'h2A: w_op = OP_ROL_A;
            8'h6A: w_op = OP_ROR_A;
            8'h06, 8'h16, 8'h0E, 8'h1E: w_op = OP_ASL_M;
            8'h46, 8'h56, 8'h4E, 8'h5E: w_op = OP_LSR_M;
            8'h26, 8'h36, 8'h2E, 8'h3E: w_op = OP_ROL_M;
            8'h66, 8'h76, 8'h6E, 8'h7E: w_op = OP_ROR_M;
            8'hE6, 8'hF6, 8'hEE, 8'hFE: w_op = OP_INC_M;
            8'hC6, 8'hD6, 8'hCE, 8'hDE: w_op = OP_DEC_M;
            8'h10, 8'h30, 8'h50, 8'h70, 8'h90, 8'hB0, 8'hD0, 8'hF0: w_op = OP_BRANCH;
            8'h24, 8'h2C: w_op = OP_BIT;
            8'h18: w_op = OP_CLC;
            8'h38: w_op = OP_SEC;
            8'hD8: w_op = OP_CLD;
            8'hF8: w_op = OP_SED;
            8'h58: w_op = OP_CLI;
            8'h78: w_op = OP_SEI;
            8'hB8: w_op = OP_CLV;
            8'hC9, 8'hC5, 8'hD5, 8'hCD, 8'hDD, 8'hD9, 8'hC1, 8'hD1: w_op = OP_CMP;
            8'hE0, 8'hE4, 8'hEC: w_op = OP_CPX;
            8'hC0, 8'hC4, 8'hCC: w_op = OP_CPY;
            8'hCA: w_op = OP_DEX;
            8'h88: w_op = OP_DEY;
            8'hE8: w_op = OP_INX;
            8'hC8: w_op = OP_INY;
            8'hA9, 8'hA5, 8'hB5, 8'hAD, 8'hBD, 8'hB9, 8'hA1, 8'hB1: w_op = OP_LDA;
            8'hA2, 8'hA6, 8'hB6, 8'hAE, 8'hBE: w_op = OP_LDX;
            8'hA0, 8'hA4, 8'hB4, 8'hAC, 8'hBC: w_op = OP_LDY;
            8'hEA: w_op = OP_NOP;
            8'h48: w_op = OP_PHA;
            8'h08: w_op = OP_PHP;
            8'h68: w_op = OP_PLA;
            8'h28: w_op = OP_PLP;
            8'h85, 8'h95, 8'h8D, 8'h9D, 8'h99, 8'h81, 8'h91: w_op = OP_STA;
            8'h86, 8'h96, 8'h8E: w_op = OP_STX;
            8'h84, 8'h94, 8'h8C: w_op = OP_STY;
            8'hAA: w_op = OP_TAX;
            8'hA8: w_op = OP_TAY;
            8'hBA: w_op = OP_TSX;
            8'h8A: w_op = OP_TXA;
            8'h9A: w_op = OP_TXS;
            8'h98: w_op = OP_TYA;
            default: w_op = OP_BAD;
        endcase
    end

    // branches: bits 7:6 pick the flag, bit 5 is the value that takes it
    assign o_ctl.op     = w_op;
    assign o_ctl.bsel   = i_opcode[7:6];
    assign o_ctl.bsense = i_opcode[5];

endmodule

FILE: sv/e8cpu_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8cpu_alu
// Execute logic: computes the next register file, flags, the write-back
// byte, the branch decision and the bad-opcode flag for one decoded instruction.
// ----------------------------------------------------------------------------
module e8cpu_alu (
    input  e8cpu_pkg::t_ctl   i_ctl,
    input  logic [7:0]        i_operand,
    input  e8cpu_pkg::t_regs  i_regs,
    output e8cpu_pkg::t_regs  o_regs,
    output logic [7:0]        o_wdata,
    output logic              o_wen,
    output logic              o_branch,
    output logic              o_bad
);
    import e8cpu_pkg::*;

    logic [7:0] w_addend;
    logic [8:0] w_sum;
    logic       w_ovf;
    logic [7:0] w_cmp_reg;
    logic [8:0] w_diff;
    logic [7:0] w_sh_in;
    logic [7:0] w_sh_res;
    logic       w_sh_c;
    logic       w_cin;
    logic       w_bflag;
    logic [7:0] w_inc;
    logic [7:0] w_dec;

    function automatic logic [6:0] with_nz(logic [6:0] f, logic [7:0] v);
        logic [6:0] r;
        r       = f;
        r[FL_Z] = (v == 8'h00);
        r[FL_N] = v[7];
        return r;
    endfunction

    assign w_cin = i_regs.flags[FL_C];

    // shared adder for ADC / SBC (SBC adds the inverted operand)
    assign w_addend = (i_ctl.op == OP_SBC) ? ~i_operand : i_operand;
    assign w_sum    = {1'b0, i_regs.acc} + {1'b0, w_addend} + {8'b0, w_cin};
    assign w_ovf    = (i_regs.acc[7] ^ w_sum[7]) & (w_addend[7] ^ w_sum[7]);

    always_comb begin
        unique case (i_ctl.op)
            OP_CPX:  w_cmp_reg = i_regs.x;
            OP_CPY:  w_cmp_reg = i_regs.y;
            default: w_cmp_reg = i_regs.acc;
        endcase
    end
    // bit 8 is the borrow, so carry = not borrow
    assign w_diff = {1'b0, w_cmp_reg} - {1'b0, i_operand};

    // shared shifter for accumulator and memory forms
    assign w_sh_in = (i_ctl.op == OP_ASL_A || i_ctl.op == OP_LSR_A ||
                      i_ctl.op == OP_ROL_A || i_ctl.op == OP_ROR_A) ? i_regs.acc : i_operand;

    always_comb begin
        unique case (i_ctl.op)
            OP_ASL_A, OP_ASL_M: begin
                w_sh_res = {w_sh_in[6:0], 1'b0};
                w_sh_c   = w_sh_in[7];
            end
            OP_ROL_A, OP_ROL_M: begin
                w_sh_res = {w_sh_in[6:0], w_cin};
                w_sh_c   = w_sh_in[7];
            end
            OP_ROR_A, OP_ROR_M: begin
                w_sh_res = {w_cin, w_sh_in[7:1]};
                w_sh_c   = w_sh_in[0];
            end
            default: begin
                w_sh_res = {1'b0, w_sh_in[7:1]};
                w_sh_c   = w_sh_in[0];
            end
        endcase
    end

    always_comb begin
        unique case (i_ctl.bsel)
            BSEL_N:  w_bflag = i_regs.flags[FL_N];
            BSEL_V:  w_bflag = i_regs.flags[FL_V];
            BSEL_C:  w_bflag = i_regs.flags[FL_C];
            BSEL_Z:  w_bflag = i_regs.flags[FL_Z];
            default: w_bflag = 1'b0;
        endcase
    end

    // one incrementer and one decrementer, source picked by the operation
    always_comb begin
        unique case (i_ctl.op)
            OP_INX, OP_DEX: begin
                w_inc = i_regs.x + 8'd1;
                w_dec = i_regs.x - 8'd1;
            end
            OP_INY, OP_DEY: begin
                w_inc = i_regs.y + 8'd1;
                w_dec = i_regs.y - 8'd1;
            end
            OP_PHA, OP_PHP, OP_PLA, OP_PLP: begin
                w_inc = i_regs.sp + 8'd1;
                w_dec = i_regs.sp - 8'd1;
            end
            default: begin
                w_inc = i_operand + 8'd1;
                w_dec = i_operand - 8'd1;
            end
        endcase
    end

    always_comb begin
        o_regs   = i_regs;
        o_wdata  = 8'h00;
        o_wen    = 1'b0;
        o_branch = 1'b0;
        o_bad    = 1'b0;
        unique case (i_ctl.op)
            OP_ADC, OP_SBC: begin
                o_regs.acc         = w_sum[7:0];
                o_regs.flags       = with_nz(i_regs.flags, w_sum[7:0]);
                o_regs.flags[FL_V] = w_ovf;
                o_regs.flags[FL_C] = w_sum[8];
            end
            OP_AND: begin
                o_regs.acc   = i_regs.acc & i_operand;
                o_regs.flags = with_nz(i_regs.flags, i_regs.acc & i_operand);
            end
            OP_ORA: begin
                o_regs.acc   = i_regs.acc | i_operand;
                o_regs.flags = with_nz(i_regs.flags, i_regs.acc | i_operand);
            end
            OP_EOR: begin
                o_regs.acc   = i_regs.acc ^ i_operand;
                o_regs.flags = with_nz(i_regs.flags, i_regs.acc ^ i_operand);
            end
            OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
                o_regs.acc         = w_sh_res;
                o_regs.flags       = with_nz(i_regs.flags, w_sh_res);
                o_regs.flags[FL_C] = w_sh_c;
            end
            OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
                o_wdata            = w_sh_res;
                o_wen              = 1'b1;
                o_regs.flags       = with_nz(i_regs.flags, w_sh_res);
                o_regs.flags[FL_C] = w_sh_c;
            end
            OP_INC_M: begin
                o_wdata      = w_inc;
                o_wen        = 1'b1;
                o_regs.flags = with_nz(i_regs.flags, w_inc);
            end
            OP_DEC_M: begin
                o_wdata      = w_dec;
                o_wen        = 1'b1;
                o_regs.flags = with_nz(i_regs.flags, w_dec);
            end
            OP_BRANCH: o_branch = (w_bflag == i_ctl.bsense);
            OP_BIT: begin
                o_regs.flags[FL_Z] = ((i_regs.acc & i_operand) == 8'h00);
                o_regs.flags[FL_V] = i_operand[6];
                o_regs.flags[FL_N] = i_operand[7];
            end
            OP_CLC: o_regs.flags[FL_C] = 1'b0;
            OP_SEC: o_regs.flags[FL_C] = 1'b1;
            OP_CLD: o_regs.flags[FL_D] = 1'b0;
            OP_SED: o_regs.flags[FL_D] = 1'b1;
            OP_CLI: o_regs.flags[FL_I] = 1'b0;
            OP_SEI: o_regs.flags[FL_I] = 1'b1;
            OP_CLV: o_regs.flags[FL_V] = 1'b0;
            OP_CMP, OP_CPX, OP_CPY: begin
                o_regs.flags       = with_nz(i_regs.flags, w_diff[7:0]);
                o_regs.flags[FL_C] = ~w_diff[8];
            end
            OP_DEX: begin
                o_regs.x     = w_dec;
                o_regs.flags = with_nz(i_regs.flags, w_dec);
            end
            OP_INX: begin
                o_regs.x     = w_inc;
                o_regs.flags = with_nz(i_regs.flags, w_inc);
            end
            OP_DEY: begin
                o_regs.y     = w_dec;
                o_regs.flags = with_nz(i_regs.flags, w_dec);
            end
            OP_INY: begin
                o_regs.y     = w_inc;
                o_regs.flags = with_nz(i_regs.flags, w_inc);
            end
            OP_LDA, OP_PLA: begin
                o_regs.acc   = i_operand;
                o_regs.flags = with_nz(i_regs.flags, i_operand);
                if (i_ctl.op == OP_PLA) begin
                    o_regs.sp = w_inc;
                end
            end
            OP_LDX: begin
                o_regs.x     = i_operand;
                o_regs.flags = with_nz(i_regs.flags, i_operand);
            end
            OP_LDY: begin
                o_regs.y     = i_operand;
                o_regs.flags = with_nz(i_regs.flags, i_operand);
            end
            OP_NOP: o_regs = i_regs;
            OP_PHA: begin
                o_wdata   = i_regs.acc;
                o_wen     = 1'b1;
                o_regs.sp = w_dec;
            end
            OP_PHP: begin
                o_wdata   = pack_status(i_regs.flags);
                o_wen     = 1'b1;
                o_regs.sp = w_dec;
            end
            OP_PLP: begin
                // bit 5 of the pulled byte is dropped
                o_regs.sp    = w_inc;
                o_regs.flags = {i_operand[7:6], i_operand[4:0]};
            end
            OP_STA: begin
                o_wdata = i_regs.acc;
                o_wen   = 1'b1;
            end
            OP_STX: begin
                o_wdata = i_regs.x;
                o_wen   = 1'b1;
            end
            OP_STY: begin
                o_wdata = i_regs.y;
                o_wen   = 1'b1;
            end
            OP_TAX: begin
                o_regs.x     = i_regs.acc;
                o_regs.flags = with_nz(i_regs.flags, i_regs.acc);
            end
            OP_TAY: begin
                o_regs.y     = i_regs.acc;
                o_regs.flags = with_nz(i_regs.flags, i_regs.acc);
            end
            OP_TSX: begin
                o_regs.x     = i_regs.sp;
                o_regs.flags = with_nz(i_regs.flags, i_regs.sp);
            end
            OP_TXA: begin
                o_regs.acc   = i_regs.x;
                o_regs.flags = with_nz(i_regs.flags, i_regs.x);
            end
            OP_TXS: o_regs.sp = i_regs.x;
            OP_TYA: begin
                o_regs.acc   = i_regs.y;
                o_regs.flags = with_nz(i_regs.flags, i_regs.y);
            end
            default: o_bad = 1'b1;
        endcase
    end

endmodule

FILE: sv/e8cpu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// e8cpu_checker
// Port-level checks on the execute unit's result stream, bound to the top.
// ----------------------------------------------------------------------------
module e8cpu_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [e8cpu_pkg::OUT_W-1:0]  m_axis_tdata
);
    import e8cpu_pkg::*;

    // no result may be pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // unknown opcode: no write, no branch, zero write byte
    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[50] |-> m_axis_tdata[9:0] == 10'd0)
        else $error("unknown opcode produced a side effect");

    // write byte is zero unless a write is flagged, and branches never write
    a_wdata_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (!m_axis_tdata[8] || m_axis_tdata[9]) |->
            m_axis_tdata[7:0] == 8'd0 && !(m_axis_tdata[8] && m_axis_tdata[9]))
        else $error("write byte without write enable");

    // packed status always has bit 5 set
    a_status_b5: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47])
        else $error("status bit 5 clear");

endmodule

bind eight_bit_cpu_execute_unit_core e8cpu_checker u_e8cpu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
